// ===== hdl/id3_pkg.sv =====
// ----------------------------------------------------------------------------
// id3_pkg
// Shared types and constants for the ID3v2 tag stripper: header layout,
// parser phase codes and the job record passed from front to back end.
// ----------------------------------------------------------------------------
package id3_pkg;

    localparam int HEADER_BYTES = 10;
    localparam int HDR_CNT_W    = 4;
    localparam int FOOTER_BYTES = 10;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [7:0] TAG_CHAR_I        = 8'h49;
    localparam logic [7:0] TAG_CHAR_D        = 8'h44;
    localparam logic [7:0] TAG_CHAR_3        = 8'h33;
    localparam logic [7:0] FOOTER_FLAG       = 8'h10;
    localparam logic [7:0] SYNC_MSB          = 8'h80;
    localparam logic [7:0] MAX_VERSION_RESET = 8'd4;

    typedef enum logic [1:0] {
        PH_COLLECT = 2'd0,
        PH_SKIP    = 2'd1,
        PH_PASS    = 2'd2
    } phase_t;

    // count == 0 is a bare end marker; otherwise bytes[0..count-1] go out
    typedef struct packed {
        logic [HDR_CNT_W-1:0]          count;
        logic                          end_mark;
        logic [31:0]                   total;
        logic [HEADER_BYTES-1:0][7:0]  bytes;
    } job_t;

endpackage

// ===== hdl/id3_front.sv =====
// ----------------------------------------------------------------------------
// id3_front
// Accepts stream bytes, collects and checks tag headers, tracks the skip
// count and running total, and posts output jobs to the queue.
// ----------------------------------------------------------------------------
module id3_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        max_version,
    input  logic              src_valid,
    output logic              src_stall,
    input  logic [7:0]        data_byte,
    input  logic              stream_end,
    input  logic              q_full,
    output logic              push,
    output id3_pkg::job_t     push_job
);

    localparam logic [id3_pkg::HDR_CNT_W-1:0] HDR_LAST =
        id3_pkg::HDR_CNT_W'(id3_pkg::HEADER_BYTES);

    id3_pkg::phase_t                     phase_reg, phase_next;
    logic [id3_pkg::HDR_CNT_W-1:0]       header_count_reg, header_count_next;
    logic [28:0]                         skip_remaining_reg, skip_remaining_next;
    logic [31:0]                         skip_total_reg, skip_total_next;
    logic [7:0]                          hdr_buf_reg [id3_pkg::HEADER_BYTES];

    logic                                accept;
    logic                                buf_wr;
    logic [id3_pkg::HDR_CNT_W-1:0]       idx;
    logic [id3_pkg::HDR_CNT_W-1:0]       cnt1;
    logic [id3_pkg::HEADER_BYTES-1:0][7:0] bytes_new;
    logic                                hdr_match;
    logic [27:0]                         size28;
    logic [28:0]                         body;
    logic [28:0]                         tag_len;
    logic [32:0]                         sum;
    logic [31:0]                         total_upd;
    logic [28:0]                         rem_dec;

    assign src_stall = q_full;
    assign accept    = src_valid && !q_full;

    always_comb
    begin
        idx  = (header_count_reg >= HDR_LAST) ? '0 : header_count_reg;
        cnt1 = idx + 1'b1;
        for (int j = 0; j < id3_pkg::HEADER_BYTES; j++)
        begin
            bytes_new[j] = (idx == id3_pkg::HDR_CNT_W'(j)) ? data_byte : hdr_buf_reg[j];
        end
    end

    // header check on the ten bytes including the one arriving now
    always_comb
    begin
        hdr_match = (bytes_new[0] == id3_pkg::TAG_CHAR_I) &&
                    (bytes_new[1] == id3_pkg::TAG_CHAR_D) &&
                    (bytes_new[2] == id3_pkg::TAG_CHAR_3) &&
                    (bytes_new[3] <= max_version) &&
                    ((bytes_new[6] & id3_pkg::SYNC_MSB) == 8'h00) &&
                    ((bytes_new[7] & id3_pkg::SYNC_MSB) == 8'h00) &&
                    ((bytes_new[8] & id3_pkg::SYNC_MSB) == 8'h00) &&
                    ((bytes_new[9] & id3_pkg::SYNC_MSB) == 8'h00);
        size28  = {bytes_new[6][6:0], bytes_new[7][6:0],
                   bytes_new[8][6:0], bytes_new[9][6:0]};
        body    = {1'b0, size28} +
                  (((bytes_new[5] & id3_pkg::FOOTER_FLAG) != 8'h00) ?
                   29'(id3_pkg::FOOTER_BYTES) : 29'd0);
        tag_len = body + 29'(id3_pkg::HEADER_BYTES);
        sum     = {1'b0, skip_total_reg} + 33'(tag_len);
        rem_dec = (skip_remaining_reg != '0) ? skip_remaining_reg - 1'b1 : skip_remaining_reg;
    end

    always_comb
    begin
        phase_next          = phase_reg;
        header_count_next   = header_count_reg;
        skip_remaining_next = skip_remaining_reg;
        total_upd           = skip_total_reg;
        buf_wr              = 1'b0;
        push                = 1'b0;
        push_job.count      = '0;
        push_job.end_mark   = stream_end;
        push_job.bytes      = bytes_new;

        if (accept)
        begin
            case (phase_reg)
                id3_pkg::PH_SKIP:
                begin
                    skip_remaining_next = rem_dec;
                    if (rem_dec == '0)
                    begin
                        phase_next = id3_pkg::PH_COLLECT;
                    end
                    push = stream_end;
                end
                id3_pkg::PH_PASS:
                begin
                    push              = 1'b1;
                    push_job.count    = id3_pkg::HDR_CNT_W'(1);
                    push_job.bytes[0] = data_byte;
                end
                default:
                begin
                    buf_wr = 1'b1;
                    if (cnt1 == HDR_LAST)
                    begin
                        header_count_next = '0;
                        if (hdr_match)
                        begin
                            total_upd           = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                            skip_remaining_next = body;
                            phase_next = (body != '0) ? id3_pkg::PH_SKIP : id3_pkg::PH_COLLECT;
                            push       = stream_end;
                        end
                        else
                        begin
                            push           = 1'b1;
                            push_job.count = HDR_LAST;
                            phase_next     = id3_pkg::PH_PASS;
                        end
                    end
                    else
                    begin
                        header_count_next = cnt1;
                        if (stream_end)
                        begin
                            push           = 1'b1;
                            push_job.count = cnt1;
                        end
                    end
                end
            endcase

            if (stream_end)
            begin
                phase_next          = id3_pkg::PH_COLLECT;
                header_count_next   = '0;
                skip_remaining_next = '0;
            end
        end

        push_job.total  = total_upd;
        skip_total_next = (accept && stream_end) ? 32'd0 : total_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= id3_pkg::PH_COLLECT;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_count_reg   <= '0;
            skip_remaining_reg <= '0;
            skip_total_reg     <= '0;
        end
        else
        begin
            header_count_reg   <= header_count_next;
            skip_remaining_reg <= skip_remaining_next;
            skip_total_reg     <= skip_total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (buf_wr)
        begin
            hdr_buf_reg[idx] <= data_byte;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        header_count_reg < HDR_LAST)
        else $error("header count out of range");

endmodule

// ===== hdl/id3_queue.sv =====
// ----------------------------------------------------------------------------
// id3_queue
// Short job FIFO between the header parser and the output sequencer.
// ----------------------------------------------------------------------------
module id3_queue
#(
    parameter int DEPTH = id3_pkg::QUEUE_DEPTH   // 2 or more
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  id3_pkg::job_t     push_job,
    output logic              full,
    input  logic              pop,
    output logic              q_valid,
    output id3_pkg::job_t     q_job
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    id3_pkg::job_t       mem [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_job   = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("job pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("job popped from empty queue");

endmodule

// ===== hdl/id3_back.sv =====
// ----------------------------------------------------------------------------
// id3_back
// Output sequencer: expands each queued job into one or more results and
// drives the result register.
// ----------------------------------------------------------------------------
module id3_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  id3_pkg::job_t     q_job,
    output logic              pop,
    output logic              res_valid,
    input  logic              res_stall,
    output logic [7:0]        out_byte,
    output logic              byte_valid,
    output logic              end_flag,
    output logic              last_of_run,
    output logic [31:0]       skipped_total
);

    logic              active_reg;
    id3_pkg::job_t     job_reg;
    logic              res_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              byte_valid_reg, end_flag_reg, last_of_run_reg;
    logic [31:0]       skipped_total_reg;

    logic              slot_free, emit, last;

    assign slot_free = !res_valid_reg || !res_stall;
    assign emit      = active_reg && slot_free;
    assign last      = (job_reg.count <= id3_pkg::HDR_CNT_W'(1));
    assign pop       = q_valid && (!active_reg || (emit && last));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                active_reg <= 1'b1;
            end
            else if (emit && last)
            begin
                active_reg <= 1'b0;
            end
            if (slot_free)
            begin
                res_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= q_job;
        end
        else if (emit)
        begin
            // step to the next buffered byte
            job_reg.count <= job_reg.count - 1'b1;
            for (int j = 0; j < id3_pkg::HEADER_BYTES - 1; j++)
            begin
                job_reg.bytes[j] <= job_reg.bytes[j + 1];
            end
        end
        if (emit)
        begin
            out_byte_reg      <= (job_reg.count != '0) ? job_reg.bytes[0] : 8'h00;
            byte_valid_reg    <= (job_reg.count != '0);
            end_flag_reg      <= job_reg.end_mark && last;
            last_of_run_reg   <= last;
            skipped_total_reg <= job_reg.total;
        end
    end

    assign res_valid     = res_valid_reg;
    assign out_byte      = out_byte_reg;
    assign byte_valid    = byte_valid_reg;
    assign end_flag      = end_flag_reg;
    assign last_of_run   = last_of_run_reg;
    assign skipped_total = skipped_total_reg;

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && end_flag) |-> last_of_run)
        else $error("end flag without last of run");

    a_bare_end: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !byte_valid) |-> (end_flag && out_byte == 8'h00))
        else $error("bare item is not a clean end marker");

endmodule

// ===== hdl/id3v2_tag_stripper.sv =====
// A byte's result goes through the job queue, job register and result register.
// Throughput: one byte per cycle while passing or skipping and the queue has room;
// a header flush of up to ten bytes leaves the output sequencer at one byte per
// cycle, so input stalls once the two-entry job queue is full.
// Reset: rst_n clears parser counters and queue pointers; max_version returns to 4.
// ----------------------------------------------------------------------------
// id3v2_tag_stripper
// Strips a chain of leading ID3v2 tags from a byte stream and reports the
// running total of removed bytes.
// ----------------------------------------------------------------------------
module id3v2_tag_stripper
#(
    parameter int QUEUE_DEPTH = id3_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        src_valid,
    output logic        src_stall,
    input  logic [7:0]  data_byte,
    input  logic        stream_end,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic        end_flag,
    output logic        last_of_run,
    output logic [31:0] skipped_total
);

    logic [7:0]      max_version_reg;
    logic            push, q_full, pop, q_valid;
    id3_pkg::job_t   push_job, q_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_version_reg <= id3_pkg::MAX_VERSION_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_version_reg <= cfg_data;
        end
    end

    id3_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .max_version (max_version_reg),
        .src_valid   (src_valid),
        .src_stall   (src_stall),
        .data_byte   (data_byte),
        .stream_end  (stream_end),
        .q_full      (q_full),
        .push        (push),
        .push_job    (push_job)
    );

    id3_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_job    (q_job)
    );

    id3_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_job         (q_job),
        .pop           (pop),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .out_byte      (out_byte),
        .byte_valid    (byte_valid),
        .end_flag      (end_flag),
        .last_of_run   (last_of_run),
        .skipped_total (skipped_total)
    );

endmodule
